### hw/rtl/psc_pkg.sv
// shared types and constants for the prime / semiprime classifier
// holds the input and result word structs and the class codes
// no dependencies
package psc_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int TALLY_BITS  = 32;
    localparam int CLASS_COUNT = 5;
    localparam int CLASS_BITS  = 3;

    typedef enum logic [CLASS_BITS-1:0] {
        CLS_PRIME          = 3'd0,
        CLS_EVEN_SEMIPRIME = 3'd1,
        CLS_ODD_SEMIPRIME  = 3'd2,
        CLS_EVEN_OTHER     = 3'd3,
        CLS_ODD_OTHER      = 3'd4
    } class_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  clear_tallies;
    } in_word_t;

    typedef struct packed {
        logic [CLASS_BITS-1:0] number_class;
        logic [TALLY_BITS-1:0] prime_tally;
        logic [TALLY_BITS-1:0] even_semiprime_tally;
        logic [TALLY_BITS-1:0] odd_semiprime_tally;
        logic [TALLY_BITS-1:0] even_other_tally;
        logic [TALLY_BITS-1:0] odd_other_tally;
        logic [TALLY_BITS-1:0] total_tally;
    } out_word_t;

endpackage

### hw/rtl/prime_semiprime_classifier.sv
// top level of the prime / semiprime classifier
// trial-division sequencer around one bit-serial remainder unit, plus class tallies
// depends on psc_pkg
//
// Takes one unsigned value per input word and returns one result word with its
// class (prime, even semiprime, odd semiprime, even other, odd other; 0 and 1 are
// other) and five saturating class tallies plus a saturating total, all counted
// after this value. clear_tallies zeroes every tally before the value is counted.
// The value is first searched for its least factor by trial division with odd
// candidates d while d*d <= value; if one is found the cofactor gets the same
// search to decide semiprime. Every candidate takes one square compare, a pass
// through the shared restoring remainder unit (one quotient bit per cycle) and
// one evaluation step. A large prime is tested against every odd candidate up
// to its root, and so is a large prime cofactor of a small least factor (for
// example twice a prime). s_ready is high only while no item is in work.
// The result sits in an output register, so the next word is taken while a
// finished result still waits for m_ready.
module prime_semiprime_classifier (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  psc_pkg::in_word_t   s_word,
    output logic                m_valid,
    input  logic                m_ready,
    output psc_pkg::out_word_t  m_word
);
    import psc_pkg::*;

    // divisor candidate width: sqrt of the value plus headroom for the last step
    localparam int DW   = (VALUE_BITS + 1) / 2 + 1;
    // running square width: stays below twice the value range
    localparam int SQW  = VALUE_BITS + 2;
    localparam int CNTW = $clog2(VALUE_BITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_TEST,
        S_DIV,
        S_EVAL,
        S_DONE
    } state_t;

    state_t                 state_reg,  state_next;
    logic [VALUE_BITS-1:0]  value_reg,  value_next;   // original value, parity source
    logic [VALUE_BITS-1:0]  target_reg, target_next;  // value under test
    logic                   pass_reg,   pass_next;    // 0 main value, 1 cofactor
    logic [DW-1:0]          d_reg,      d_next;       // odd divisor candidate
    logic [SQW-1:0]         sq_reg,     sq_next;      // d * d, kept by adds
    logic [DW-1:0]          rem_reg,    rem_next;
    logic [VALUE_BITS-1:0]  quo_reg,    quo_next;     // dividend in, quotient out
    logic [CNTW-1:0]        cnt_reg,    cnt_next;
    class_t                 cls_reg,    cls_next;
    logic [TALLY_BITS-1:0]  tally_reg [CLASS_COUNT];
    logic [TALLY_BITS-1:0]  tally_next [CLASS_COUNT];
    logic [TALLY_BITS-1:0]  total_reg,  total_next;
    logic                   m_valid_reg, m_valid_next;
    out_word_t              m_word_reg,  m_word_next;

    // shared remainder unit: one restoring step
    logic [DW:0]            rem_shift;
    logic [DW:0]            rem_diff;
    logic                   qbit;

    // saturating increments for the finishing item
    logic [TALLY_BITS-1:0]  cls_tally;
    logic [TALLY_BITS-1:0]  cls_tally_inc;
    logic [TALLY_BITS-1:0]  total_inc;

    class_t                 cls_semi;
    class_t                 cls_other;
    logic                   accept;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    assign rem_shift = {rem_reg, quo_reg[VALUE_BITS-1]};
    assign rem_diff  = rem_shift - {1'b0, d_reg};
    assign qbit      = !rem_diff[DW];

    assign cls_semi  = value_reg[0] ? CLS_ODD_SEMIPRIME : CLS_EVEN_SEMIPRIME;
    assign cls_other = value_reg[0] ? CLS_ODD_OTHER : CLS_EVEN_OTHER;

    assign cls_tally     = tally_reg[cls_reg];
    assign cls_tally_inc = (cls_tally == '1) ? cls_tally : cls_tally + TALLY_BITS'(1);
    assign total_inc     = (total_reg == '1) ? total_reg : total_reg + TALLY_BITS'(1);

    always_comb begin
        state_next   = state_reg;
        value_next   = value_reg;
        target_next  = target_reg;
        pass_next    = pass_reg;
        d_next       = d_reg;
        sq_next      = sq_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        cnt_next     = cnt_reg;
        cls_next     = cls_reg;
        tally_next   = tally_reg;
        total_next   = total_reg;
        m_valid_next = m_valid_reg;
        m_word_next  = m_word_reg;

        // result leaves when the sink takes it
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    value_next  = s_word.value;
                    target_next = s_word.value;
                    pass_next   = 1'b0;
                    // clear happens before this value is counted
                    if (s_word.clear_tallies) begin
                        for (int i = 0; i < CLASS_COUNT; i++) begin
                            tally_next[i] = '0;
                        end
                        total_next = '0;
                    end
                    state_next = S_CHECK;
                end
            end

            S_CHECK: begin
                // cheap cases first: below two, and even values
                if (!pass_reg && target_reg < VALUE_BITS'(2)) begin
                    cls_next   = cls_other;
                    state_next = S_DONE;
                end else if (!target_reg[0]) begin
                    if (!pass_reg) begin
                        if (target_reg == VALUE_BITS'(2)) begin
                            cls_next   = CLS_PRIME;
                            state_next = S_DONE;
                        end else begin
                            // least factor is two, cofactor is the half
                            target_next = target_reg >> 1;
                            pass_next   = 1'b1;
                        end
                    end else begin
                        cls_next   = (target_reg == VALUE_BITS'(2)) ? cls_semi : cls_other;
                        state_next = S_DONE;
                    end
                end else begin
                    d_next     = DW'(3);
                    sq_next    = SQW'(9);
                    state_next = S_TEST;
                end
            end

            S_TEST: begin
                if (sq_reg > SQW'(target_reg)) begin
                    // no factor up to the root: target is prime
                    cls_next   = pass_reg ? cls_semi : CLS_PRIME;
                    state_next = S_DONE;
                end else begin
                    quo_next   = target_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end

            S_DIV: begin
                rem_next = qbit ? rem_diff[DW-1:0] : rem_shift[DW-1:0];
                quo_next = {quo_reg[VALUE_BITS-2:0], qbit};
                cnt_next = cnt_reg + CNTW'(1);
                if (cnt_reg == CNTW'(VALUE_BITS - 1)) begin
                    state_next = S_EVAL;
                end
            end

            S_EVAL: begin
                if (rem_reg == '0) begin
                    if (!pass_reg) begin
                        // composite: now test the cofactor
                        target_next = quo_reg;
                        pass_next   = 1'b1;
                        state_next  = S_CHECK;
                    end else begin
                        cls_next   = cls_other;
                        state_next = S_DONE;
                    end
                end else begin
                    // (d+2)^2 = d^2 + 4d + 4
                    d_next     = d_reg + DW'(2);
                    sq_next    = sq_reg + SQW'({d_reg, 2'b00}) + SQW'(4);
                    state_next = S_TEST;
                end
            end

            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    tally_next[cls_reg] = cls_tally_inc;
                    total_next          = total_inc;
                    m_word_next.number_class         = cls_reg;
                    m_word_next.prime_tally          = tally_next[CLS_PRIME];
                    m_word_next.even_semiprime_tally = tally_next[CLS_EVEN_SEMIPRIME];
                    m_word_next.odd_semiprime_tally  = tally_next[CLS_ODD_SEMIPRIME];
                    m_word_next.even_other_tally     = tally_next[CLS_EVEN_OTHER];
                    m_word_next.odd_other_tally      = tally_next[CLS_ODD_OTHER];
                    m_word_next.total_tally          = total_inc;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            total_reg   <= '0;
            for (int i = 0; i < CLASS_COUNT; i++) begin
                tally_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            total_reg   <= total_next;
            tally_reg   <= tally_next;
        end
        value_reg  <= value_next;
        target_reg <= target_next;
        pass_reg   <= pass_next;
        d_reg      <= d_next;
        sq_reg     <= sq_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
        cls_reg    <= cls_next;
        m_word_reg <= m_word_next;
    end

`ifndef SYNTH
    // running square tracks the candidate
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TEST || state_reg == S_DIV) |->
            (sq_reg == SQW'(SQW'(d_reg) * SQW'(d_reg)) && d_reg[0]))
        else $error("square register out of step with divisor candidate");

    // partial remainder never reaches the divisor
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV || state_reg == S_EVAL) |-> (rem_reg < d_reg))
        else $error("partial remainder not below divisor");

    // the total is at least the prime, even semiprime and odd other class counts
    assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg >= tally_reg[CLS_PRIME] && total_reg >= tally_reg[CLS_ODD_OTHER]
        && total_reg >= tally_reg[CLS_EVEN_SEMIPRIME])
        else $error("total tally below a class tally");

    // a finished item waits while the output register is still occupied
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && m_valid_reg && !m_ready) |=>
            (state_reg == S_DONE && m_valid_reg))
        else $error("result overwrote a word not yet taken");
`endif

endmodule

### bench/prime_semiprime_classifier_tb.sv
// self-checking bench for prime_semiprime_classifier: directed rows, then random words
// predicts class and saturating tallies in-bench, compares every result word field by field
// depends on psc_pkg and the rtl top level
module prime_semiprime_classifier_tb;
    import psc_pkg::*;

    // run shape
    localparam int unsigned RANDOM_WORDS     = 78;
    localparam int unsigned LIMIT_CYCLES     = 3_000_000;
    localparam int unsigned DRAIN_CYCLES     = 200;
    localparam int unsigned LONG_HOLD_AT     = 30;
    localparam int unsigned LONG_HOLD_CYCLES = 6000;

    // one directed row: stimulus word plus an optional hand-written result
    typedef struct {
        in_word_t  stim;
        bit        typed;
        out_word_t want;
    } stim_row_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_word_t   s_word;
    logic       m_valid;
    logic       m_ready;
    out_word_t  m_word;

    // predictor state: per-class tallies and the running total
    logic [TALLY_BITS-1:0] class_counts [CLASS_COUNT];
    logic [TALLY_BITS-1:0] values_counted;

    // results still owed by the block, oldest first
    out_word_t   pending_results [$];
    stim_row_t   directed_rows [$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    prime_semiprime_classifier uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    always #5 aclk = ~aclk;

    // watchdog: a hung block or a lost result ends here
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------- prediction

    // smallest divisor >= 2 by trial division, or v itself when none up to sqrt(v)
    function automatic longint unsigned least_factor(longint unsigned v);
        longint unsigned d;
        if (v % 2 == 0) return 2;
        d = 3;
        while (d * d <= v) begin
            if (v % d == 0) return d;
            d += 2;
        end
        return v;
    endfunction

    function automatic bit is_prime(longint unsigned v);
        if (v < 2) return 1'b0;
        return least_factor(v) == v;
    endfunction

    // product of exactly two primes, squares included
    function automatic bit is_semiprime(longint unsigned v);
        longint unsigned p;
        if (v < 4) return 1'b0;
        p = least_factor(v);
        if (p == v) return 1'b0;
        return is_prime(v / p);
    endfunction

    // tallies stick at all ones
    function automatic logic [TALLY_BITS-1:0] bump(logic [TALLY_BITS-1:0] t);
        return (&t) ? t : t + 1'b1;
    endfunction

    // classify one word, update the tallies, return the result word it should produce
    function automatic out_word_t classify_and_count(in_word_t w);
        class_t    cls;
        out_word_t r;
        longint unsigned v;
        v = w.value;
        if (w.clear_tallies) begin
            foreach (class_counts[i]) class_counts[i] = '0;
            values_counted = '0;
        end
        if (is_prime(v))
            cls = CLS_PRIME;
        else if (is_semiprime(v))
            cls = w.value[0] ? CLS_ODD_SEMIPRIME : CLS_EVEN_SEMIPRIME;
        else
            cls = w.value[0] ? CLS_ODD_OTHER : CLS_EVEN_OTHER;
        class_counts[cls] = bump(class_counts[cls]);
        values_counted    = bump(values_counted);
        r.number_class         = cls;
        r.prime_tally          = class_counts[CLS_PRIME];
        r.even_semiprime_tally = class_counts[CLS_EVEN_SEMIPRIME];
        r.odd_semiprime_tally  = class_counts[CLS_ODD_SEMIPRIME];
        r.even_other_tally     = class_counts[CLS_EVEN_OTHER];
        r.odd_other_tally      = class_counts[CLS_ODD_OTHER];
        r.total_tally          = values_counted;
        return r;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(string what, logic [TALLY_BITS-1:0] got,
                                   logic [TALLY_BITS-1:0] want);
        mismatch_count++;
        $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
    endtask

    task automatic check_field(string what, logic [TALLY_BITS-1:0] got,
                               logic [TALLY_BITS-1:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    // every taken result word is matched against the oldest owed result
    always @(posedge aclk) begin : result_check
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result word with nothing pending, class",
                                TALLY_BITS'(m_word.number_class), '0);
            end else begin
                want = pending_results.pop_front();
                check_field("number_class", TALLY_BITS'(m_word.number_class),
                            TALLY_BITS'(want.number_class));
                check_field("prime_tally", m_word.prime_tally, want.prime_tally);
                check_field("even_semiprime_tally", m_word.even_semiprime_tally,
                            want.even_semiprime_tally);
                check_field("odd_semiprime_tally", m_word.odd_semiprime_tally,
                            want.odd_semiprime_tally);
                check_field("even_other_tally", m_word.even_other_tally,
                            want.even_other_tally);
                check_field("odd_other_tally", m_word.odd_other_tally, want.odd_other_tally);
                check_field("total_tally", m_word.total_tally, want.total_tally);
            end
        end
    end

    // ---------------------------------------------------------------- result side

    // m_ready: short random stalls, ready bursts, rare long stalls, and one very long
    // hold-off so the output register fills and s_ready stays low
    initial begin : result_sink
        int unsigned hold_left;
        int unsigned burst_left;
        int unsigned taken;
        int unsigned pick;
        bit          long_done;
        hold_left  = 0;
        burst_left = 0;
        taken      = 0;
        long_done  = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid === 1'b1 && m_ready) taken++;
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (taken == LONG_HOLD_AT && !long_done) begin
                long_done = 1'b1;
                hold_left = LONG_HOLD_CYCLES;
                m_ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (burst_left != 0) begin
                burst_left--;
                m_ready <= 1'b1;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 15) begin
                    burst_left = $urandom_range(50, 400);
                    m_ready <= 1'b1;
                end else if (pick < 50) begin
                    hold_left = $urandom_range(0, 3);
                    m_ready <= 1'b0;
                end else if (pick < 55) begin
                    hold_left = $urandom_range(20, 150);
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        end
    end

    // ---------------------------------------------------------------- input side

    // present one word and hold it until taken; the expected result is queued on acceptance
    task automatic offer_word(in_word_t w, bit typed, out_word_t want);
        out_word_t predicted;
        s_valid <= 1'b1;
        s_word  <= w;
        do @(posedge aclk); while (s_ready !== 1'b1);
        // predictor runs on every word so its tallies track the block
        predicted = classify_and_count(w);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // gap between words: mostly none or short, sometimes long
    task automatic idle_sender();
        int unsigned pick;
        int unsigned gap;
        pick = $urandom_range(0, 99);
        if (pick < 45)      gap = 0;
        else if (pick < 90) gap = $urandom_range(1, 4);
        else                gap = $urandom_range(15, 100);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic out_word_t typed_result(class_t cls, int unsigned pr, int unsigned es,
                                               int unsigned os, int unsigned eo,
                                               int unsigned oo, int unsigned tot);
        out_word_t r;
        r.number_class         = cls;
        r.prime_tally          = pr;
        r.even_semiprime_tally = es;
        r.odd_semiprime_tally  = os;
        r.even_other_tally     = eo;
        r.odd_other_tally      = oo;
        r.total_tally          = tot;
        return r;
    endfunction

    function automatic stim_row_t row(logic [VALUE_BITS-1:0] v, logic clr, bit typed,
                                      out_word_t want);
        stim_row_t r;
        r.stim.value         = v;
        r.stim.clear_tallies = clr;
        r.typed              = typed;
        r.want               = want;
        return r;
    endfunction

    // random value: mostly small numbers (cheap to factor), some built products of
    // primes for semiprime coverage, and full-width multiples of two small primes so
    // every value bit moves without handing the block a slow large prime
    function automatic logic [VALUE_BITS-1:0] pick_value();
        int unsigned some_primes [18] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37,
                                          101, 251, 257, 4093, 65521, 65537};
        int unsigned pick;
        int unsigned p;
        int unsigned q;
        int unsigned r;
        pick = $urandom_range(0, 99);
        if (pick < 55) return $urandom_range(0, 4095);
        if (pick < 70) return $urandom_range(4096, 65535);
        if (pick < 85) begin
            // one small prime times any listed prime, squares included
            p = some_primes[$urandom_range(0, 11)];
            q = some_primes[$urandom_range(0, 17)];
            return p * q;
        end
        p = some_primes[$urandom_range(0, 5)];
        q = some_primes[$urandom_range(0, 5)];
        r = $urandom_range(0, 32'hFFFF_FFFF / (p * q));
        return r * p * q;
    endfunction

    // ---------------------------------------------------------------- main sequence

    initial begin : stimulus
        in_word_t w;
        foreach (class_counts[i]) class_counts[i] = '0;
        values_counted = '0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_word  <= '0;

        // directed rows: hand-written results only where they are obvious
        // zero and one are neither prime nor semiprime, counted right after reset
        directed_rows.push_back(row(32'd0, 1'b0, 1'b1,
                                    typed_result(CLS_EVEN_OTHER, 0, 0, 0, 1, 0, 1)));
        directed_rows.push_back(row(32'd1, 1'b0, 1'b1,
                                    typed_result(CLS_ODD_OTHER, 0, 0, 0, 1, 1, 2)));
        // clear with count: the cleared class tally restarts at one
        directed_rows.push_back(row(32'd2, 1'b1, 1'b1,
                                    typed_result(CLS_PRIME, 1, 0, 0, 0, 0, 1)));
        directed_rows.push_back(row(32'd3, 1'b0, 1'b0, '0));
        directed_rows.push_back(row(32'd4, 1'b0, 1'b0, '0));   // even prime square
        directed_rows.push_back(row(32'd9, 1'b0, 1'b0, '0));   // odd prime square
        directed_rows.push_back(row(32'd6, 1'b0, 1'b0, '0));
        directed_rows.push_back(row(32'd15, 1'b0, 1'b0, '0));
        directed_rows.push_back(row(32'd8, 1'b0, 1'b0, '0));
        directed_rows.push_back(row(32'd27, 1'b0, 1'b0, '0));
        // all ones is 3*5*17*257*65537, odd and not semiprime
        directed_rows.push_back(row(32'hFFFF_FFFF, 1'b1, 1'b1,
                                    typed_result(CLS_ODD_OTHER, 0, 0, 0, 0, 1, 1)));
        directed_rows.push_back(row(32'h8000_0000, 1'b0, 1'b1,
                                    typed_result(CLS_EVEN_OTHER, 0, 0, 0, 1, 1, 2)));
        directed_rows.push_back(row(32'h5555_5555, 1'b0, 1'b0, '0));
        directed_rows.push_back(row(32'hAAAA_AAAA, 1'b0, 1'b0, '0));
        directed_rows.push_back(row(32'd65521, 1'b0, 1'b0, '0));
        directed_rows.push_back(row(32'd16777213, 1'b0, 1'b0, '0));
        directed_rows.push_back(row(32'd33554426, 1'b0, 1'b0, '0));
        directed_rows.push_back(row(32'd50331639, 1'b0, 1'b0, '0));
        directed_rows.push_back(row(32'd49, 1'b0, 1'b0, '0));
        directed_rows.push_back(row(32'd10, 1'b1, 1'b0, '0));
        directed_rows.push_back(row(32'hFFFF_FFFF, 1'b0, 1'b0, '0));
        directed_rows.push_back(row(32'd0, 1'b1, 1'b0, '0));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            offer_word(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
            idle_sender();
        end
        s_valid <= 1'b0;

        // sender pause: let every owed result come back before the random part
        while (pending_results.size() != 0) @(posedge aclk);

        repeat (RANDOM_WORDS) begin
            w.value         = pick_value();
            w.clear_tallies = ($urandom_range(0, 99) < 8);
            offer_word(w, 1'b0, '0);
            idle_sender();
        end
        s_valid <= 1'b0;

        // drain, then a quiet spell to catch any stray result word
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
